// ===== design/fomf_pkg.sv =====
// Package for the filtered overwrite message queue.
// Holds widths, command codes, register indexes and controller command types.
// No dependencies.
package fomf_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int MAX_IDS_DEF       = 4;
  localparam int ID_WIDTH_DEF      = 8;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int CMD_W      = 2;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ID_REGS    = 4;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_CHK  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID_BASE   = 3'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== design/fomf_in_if.sv =====
// Request channel interface for the message queue.
// Depends on fomf_pkg for the command width.
interface fomf_in_if #(
  parameter int ID_WIDTH      = fomf_pkg::ID_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = fomf_pkg::PAYLOAD_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [fomf_pkg::CMD_W-1:0]     command;
  logic [ID_WIDTH-1:0]            message_id;
  logic [PAYLOAD_WIDTH-1:0]       message_payload;

  modport source (output valid, command, message_id, message_payload, input ready);
  modport sink   (input valid, command, message_id, message_payload, output ready);
endinterface

// ===== design/fomf_out_if.sv =====
// Result channel interface for the message queue.
// Depends on fomf_pkg for the fill count width.
interface fomf_out_if #(
  parameter int ID_WIDTH      = fomf_pkg::ID_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = fomf_pkg::PAYLOAD_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       done_res;
  logic [ID_WIDTH-1:0]        out_id;
  logic [PAYLOAD_WIDTH-1:0]   out_payload;
  logic [fomf_pkg::CNT_W-1:0] fill_count;

  modport source (output valid, done_res, out_id, out_payload, fill_count, input ready);
  modport sink   (input valid, done_res, out_id, out_payload, fill_count, output ready);
endinterface

// ===== design/fomf_cfg_if.sv =====
// Configuration write channel interface for the message queue.
// Depends on fomf_pkg for index and data widths.
interface fomf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fomf_pkg::CFG_IDX_W-1:0]  index;
  logic [fomf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/filtered_overwrite_message_fifo.sv =====
// Top level of the filtered overwrite message queue.
// Joins fomf_ctrl and fomf_datapath; uses fomf_pkg and the channel interfaces.
//
//   channel | direction | contents
//   in_ch   | sink      | command, message_id, message_payload
//   out_ch  | source    | done_res, out_id, out_payload, fill_count
//   cfg_ch  | sink      | index, data (always ready)
//
// A request is first captured while the head slot is read from the slot memory,
// then it is executed and the result register is loaded.
// A new request is taken while the previous result still waits on out_ch.
// Execution stalls while the result register is full and not taken.
// Reset is synchronous and active low; the slot memories are not cleared.
module filtered_overwrite_message_fifo #(
  parameter int DEPTH         = fomf_pkg::DEPTH_DEF,
  parameter int MAX_IDS       = fomf_pkg::MAX_IDS_DEF,
  parameter int ID_WIDTH      = fomf_pkg::ID_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = fomf_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fomf_in_if.sink     in_ch,
  fomf_out_if.source  out_ch,
  fomf_cfg_if.sink    cfg_ch
);

  fomf_pkg::ctrl_cmd_t ctl;

  assign cfg_ch.ready = 1'b1;

  fomf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  fomf_datapath #(
    .DEPTH         (DEPTH),
    .MAX_IDS       (MAX_IDS),
    .ID_WIDTH      (ID_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .in_command         (in_ch.command),
    .in_message_id      (in_ch.message_id),
    .in_message_payload (in_ch.message_payload),
    .cfg_we             (cfg_ch.valid && cfg_ch.ready),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_done_res       (out_ch.done_res),
    .out_id             (out_ch.out_id),
    .out_payload        (out_ch.out_payload),
    .out_fill_count     (out_ch.fill_count)
  );

  a_load_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while previous one still executing");

  a_load_exec_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.exec))
    else $error("load and execute in the same cycle");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> out_ch.valid)
    else $error("execute did not present a result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !ctl.exec)
    else $error("result register overwritten before it was taken");

endmodule

// ===== design/fomf_ctrl.sv =====
// Controller state machine for the message queue.
// Sequences load and execute of one request; depends on fomf_pkg.
module fomf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output fomf_pkg::ctrl_cmd_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    ctl.load      = in_valid && in_ready;
    ctl.exec      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (ctl.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (ctl.exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/fomf_datapath.sv =====
// Datapath of the message queue: configuration registers, slot memories,
// pointers, fill count and result register. Depends on fomf_pkg.
module fomf_datapath #(
  parameter int DEPTH         = fomf_pkg::DEPTH_DEF,
  parameter int MAX_IDS       = fomf_pkg::MAX_IDS_DEF,
  parameter int ID_WIDTH      = fomf_pkg::ID_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = fomf_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fomf_pkg::ctrl_cmd_t             ctl,
  input  logic [fomf_pkg::CMD_W-1:0]      in_command,
  input  logic [ID_WIDTH-1:0]             in_message_id,
  input  logic [PAYLOAD_WIDTH-1:0]        in_message_payload,
  input  logic                            cfg_we,
  input  logic [fomf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fomf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_done_res,
  output logic [ID_WIDTH-1:0]             out_id,
  output logic [PAYLOAD_WIDTH-1:0]        out_payload,
  output logic [fomf_pkg::CNT_W-1:0]      out_fill_count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = ((PTR_W > fomf_pkg::CNT_W) ? PTR_W : fomf_pkg::CNT_W) + 1;
  localparam int CNT_W = fomf_pkg::CNT_W;

  logic [CNT_W-1:0]         cap_r;
  logic                     ovw_r;
  logic [2:0]               id_count_r;
  logic [ID_WIDTH-1:0]      acc_id_r [MAX_IDS];

  logic [ID_WIDTH-1:0]      id_mem  [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];
  logic [ID_WIDTH-1:0]      rd_id_r;
  logic [PAYLOAD_WIDTH-1:0] rd_pay_r;

  logic [PTR_W-1:0]         head_r, head_nxt;
  logic [PTR_W-1:0]         tail_r, tail_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;

  fomf_pkg::cmd_t           cmd_r;
  logic [ID_WIDTH-1:0]      id_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;

  logic                     done_r, done_nxt;
  logic [ID_WIDTH-1:0]      oid_r, oid_nxt;
  logic [PAYLOAD_WIDTH-1:0] opay_r, opay_nxt;
  logic [CNT_W-1:0]         ofill_r;

  logic [CNT_W-1:0]         cap_eff;
  logic                     id_hit;
  logic                     wr_en;
  int                       id_lim;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                              input logic [CNT_W-1:0] cap);
    logic [CMP_W-1:0] n;
    n = CMP_W'(p) + CMP_W'(1);
    return (n >= CMP_W'(cap)) ? PTR_W'(0) : PTR_W'(n);
  endfunction

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_r) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  always_comb begin
    id_lim = (int'(id_count_r) > MAX_IDS) ? MAX_IDS : int'(id_count_r);
    id_hit = 1'b0;
    for (int i = 0; i < MAX_IDS; i++) begin
      if ((i < id_lim) && (acc_id_r[i] == id_r)) begin
        id_hit = 1'b1;
      end
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    done_nxt = 1'b0;
    oid_nxt  = '0;
    opay_nxt = '0;
    wr_en    = 1'b0;
    unique case (cmd_r)
      fomf_pkg::CMD_ENQ: begin
        if (id_hit) begin
          if (fill_r < cap_eff) begin
            wr_en    = 1'b1;
            tail_nxt = advance(tail_r, cap_eff);
            fill_nxt = fill_r + CNT_W'(1);
            done_nxt = 1'b1;
          end else if (ovw_r) begin
            wr_en    = 1'b1;
            tail_nxt = advance(tail_r, cap_eff);
            head_nxt = advance(head_r, cap_eff);
            done_nxt = 1'b1;
          end
        end
      end
      fomf_pkg::CMD_DEQ: begin
        if (fill_r != '0) begin
          oid_nxt  = rd_id_r;
          opay_nxt = rd_pay_r;
          head_nxt = advance(head_r, cap_eff);
          fill_nxt = fill_r - CNT_W'(1);
          done_nxt = 1'b1;
        end
      end
      fomf_pkg::CMD_CHK: begin
        done_nxt = (fill_r != '0) && (rd_id_r == id_r);
      end
      fomf_pkg::CMD_NONE: begin
        done_nxt = 1'b0;
      end
      default: done_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= fomf_pkg::CAP_RESET;
      ovw_r      <= 1'b0;
      id_count_r <= '0;
      for (int i = 0; i < MAX_IDS; i++) begin
        acc_id_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == fomf_pkg::REG_CAPACITY) begin
        cap_r <= cfg_data[CNT_W-1:0];
      end else if (cfg_index == fomf_pkg::REG_OVERWRITE) begin
        ovw_r <= cfg_data[0];
      end else if (cfg_index == fomf_pkg::REG_ID_COUNT) begin
        id_count_r <= cfg_data[2:0];
      end else begin
        for (int i = 0; i < MAX_IDS; i++) begin
          if ((i < fomf_pkg::ID_REGS) &&
              (int'(cfg_index) == int'(fomf_pkg::REG_ID_BASE) + i)) begin
            acc_id_r[i] <= cfg_data[ID_WIDTH-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else if (ctl.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      id_mem[tail_r]  <= id_r;
      pay_mem[tail_r] <= pay_r;
    end
    rd_id_r  <= id_mem[head_r];
    rd_pay_r <= pay_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= fomf_pkg::cmd_t'(in_command);
      id_r  <= in_message_id;
      pay_r <= in_message_payload;
    end
    if (ctl.exec) begin
      done_r  <= done_nxt;
      oid_r   <= oid_nxt;
      opay_r  <= opay_nxt;
      ofill_r <= fill_nxt;
    end
  end

  assign out_done_res   = done_r;
  assign out_id         = oid_r;
  assign out_payload    = opay_r;
  assign out_fill_count = ofill_r;

endmodule

// ===== dv/filtered_overwrite_message_fifo_tb.sv =====
// Self-checking testbench for filtered_overwrite_message_fifo.
// Drives requests and configuration writes through the channel interfaces and
// predicts every result in step; depends on fomf_pkg and the fomf_*_if files.
`timescale 1ns / 100ps

module filtered_overwrite_message_fifo_tb;

  localparam int SLOTS = fomf_pkg::DEPTH_DEF;
  localparam int PTR_W = $clog2(fomf_pkg::DEPTH_DEF);
  localparam int ID_W = fomf_pkg::ID_WIDTH_DEF;
  localparam int PAY_W = fomf_pkg::PAYLOAD_WIDTH_DEF;
  localparam int CNT_W = fomf_pkg::CNT_W;
  localparam int CFG_IDX_W = fomf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = fomf_pkg::CFG_DATA_W;
  localparam int ID_REGS = fomf_pkg::ID_REGS;
  localparam int ID_SEL_W = $clog2(fomf_pkg::ID_REGS);
  localparam int MAX_IDS = fomf_pkg::MAX_IDS_DEF;
  localparam int ITEM_TARGET = 1250;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END =
    fomf_pkg::REG_ID_BASE + CFG_IDX_W'(ID_REGS);

  typedef struct packed {
    fomf_pkg::cmd_t   command;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
  } request_t;

  typedef struct packed {
    logic             done;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic [CNT_W-1:0] fill;
  } result_t;

  logic clk;
  logic rst_n;

  fomf_in_if  in_ch();
  fomf_out_if out_ch();
  fomf_cfg_if cfg_ch();

  filtered_overwrite_message_fifo dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [CNT_W-1:0] cap_reg;
  logic             overwrite_reg;
  logic [2:0]       id_count_reg;
  logic [ID_W-1:0]  accept_id [ID_REGS];
  logic [ID_W-1:0]  slot_id [SLOTS];
  logic [PAY_W-1:0] slot_payload [SLOTS];
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [CNT_W-1:0] fill_level;

  result_t pending_results[$];

  bit in_gap_on;
  bit out_stall_on;
  int hold_off_cycles;
  int requests_sent;
  int results_checked;
  int mismatches;
  int phase_count;
  int stored_count;
  int overwrite_count;
  int reject_count;
  int delivered_count;
  int match_count;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("filtered_overwrite_message_fifo test failed");
    $finish;
  end

  function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic result_t predict_request(request_t req);
    result_t          res;
    logic [CNT_W-1:0] cap;
    int               id_limit;
    int               i;
    logic             hit;
    res = '0;
    cap = (cap_reg == 0) ? CNT_W'(1) : (cap_reg > SLOTS) ? CNT_W'(SLOTS) : cap_reg;
    id_limit = (id_count_reg > MAX_IDS) ? MAX_IDS : int'(id_count_reg);
    hit = 1'b0;
    for (i = 0; i < id_limit; i++) begin
      if (accept_id[i] == req.id) hit = 1'b1;
    end
    case (req.command)
      fomf_pkg::CMD_ENQ: begin
        if (hit && (fill_level < cap || overwrite_reg)) begin
          slot_id[tail_ptr] = req.id;
          slot_payload[tail_ptr] = req.payload;
          tail_ptr = next_slot(tail_ptr, cap);
          if (fill_level < cap) begin
            fill_level++;
            stored_count++;
          end else begin
            head_ptr = next_slot(head_ptr, cap);
            overwrite_count++;
          end
          res.done = 1'b1;
        end else begin
          reject_count++;
        end
      end
      fomf_pkg::CMD_DEQ: begin
        if (fill_level > 0) begin
          res.id = slot_id[head_ptr];
          res.payload = slot_payload[head_ptr];
          head_ptr = next_slot(head_ptr, cap);
          fill_level--;
          res.done = 1'b1;
          delivered_count++;
        end
      end
      fomf_pkg::CMD_CHK: begin
        if (fill_level > 0 && slot_id[head_ptr] == req.id) begin
          res.done = 1'b1;
          match_count++;
        end
      end
      default: ;
    endcase
    res.fill = fill_level;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(fomf_pkg::cmd_t command, logic [ID_W-1:0] id,
                              logic [PAY_W-1:0] payload);
    request_t req;
    int       gap;
    req.command = command;
    req.id = id;
    req.payload = payload;
    gap = in_gap_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= command;
    in_ch.message_id <= id;
    in_ch.message_payload <= payload;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_request(req));
    requests_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      fomf_pkg::REG_CAPACITY: cap_reg = data[CNT_W-1:0];
      fomf_pkg::REG_OVERWRITE: overwrite_reg = data[0];
      fomf_pkg::REG_ID_COUNT: id_count_reg = data[2:0];
      default: begin
        if (index >= fomf_pkg::REG_ID_BASE && index < REG_PAST_END) begin
          accept_id[ID_SEL_W'(index - fomf_pkg::REG_ID_BASE)] = data[ID_W-1:0];
        end
      end
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic request_t random_request(int enq_pct, int deq_pct);
    request_t req;
    int       r;
    int       id_limit;
    r = $urandom_range(0, 99);
    id_limit = (id_count_reg > MAX_IDS) ? MAX_IDS : int'(id_count_reg);
    req.payload = $urandom();
    req.id = ID_W'($urandom_range(0, 255));
    if (r < enq_pct) begin
      req.command = fomf_pkg::CMD_ENQ;
      if (id_limit > 0 && $urandom_range(0, 3) != 0) begin
        req.id = accept_id[ID_SEL_W'($urandom_range(0, id_limit - 1))];
      end
    end else if (r < enq_pct + deq_pct) begin
      req.command = fomf_pkg::CMD_DEQ;
    end else if (r < 97) begin
      req.command = fomf_pkg::CMD_CHK;
      if (fill_level > 0 && $urandom_range(0, 1) != 0) req.id = slot_id[head_ptr];
    end else begin
      req.command = fomf_pkg::CMD_NONE;
    end
    return req;
  endfunction

  function automatic logic [ID_W-1:0] random_accept_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return ID_W'($urandom_range(0, 255));
  endfunction

  task automatic random_config();
    int               sel;
    int               i;
    logic [CNT_W-1:0] cap;
    logic [2:0]       count;
    sel = $urandom_range(0, 9);
    case (sel)
      0: cap = CNT_W'(0);
      1: cap = CNT_W'(1);
      2: cap = CNT_W'(SLOTS);
      3: cap = CNT_W'($urandom_range(SLOTS + 1, 31));
      4: cap = CNT_W'(2);
      default: cap = CNT_W'($urandom_range(1, SLOTS));
    endcase
    sel = $urandom_range(0, 9);
    count = (sel == 0) ? 3'd0 : (sel == 1) ? 3'($urandom_range(5, 7)) :
            3'($urandom_range(1, 4));
    write_reg(fomf_pkg::REG_CAPACITY, ($urandom() & ~32'h1F) | 32'(cap));
    write_reg(fomf_pkg::REG_OVERWRITE, $urandom());
    write_reg(fomf_pkg::REG_ID_COUNT, ($urandom() & ~32'h7) | 32'(count));
    for (i = 0; i < ID_REGS; i++) begin
      write_reg(fomf_pkg::REG_ID_BASE + CFG_IDX_W'(i),
                ($urandom() & ~32'hFF) | 32'(random_accept_id()));
    end
    write_reg(REG_PAST_END, $urandom());
  endtask

  task automatic test_reset_state();
    send_request(fomf_pkg::CMD_ENQ, 8'h00, 32'h0000_0000);
    send_request(fomf_pkg::CMD_DEQ, 8'h00, 32'h0000_0000);
    send_request(fomf_pkg::CMD_CHK, 8'h00, 32'h0000_0000);
    send_request(fomf_pkg::CMD_NONE, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_to_full();
    logic [ID_W-1:0]  ids [ID_REGS];
    logic [PAY_W-1:0] payload;
    int               i;
    ids = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    wait_idle();
    write_reg(fomf_pkg::REG_ID_COUNT, 32'd4);
    for (i = 0; i < ID_REGS; i++) begin
      write_reg(fomf_pkg::REG_ID_BASE + CFG_IDX_W'(i), 32'(ids[i]));
    end
    for (i = 0; i < SLOTS; i++) begin
      case (i)
        0: payload = 32'h0000_0000;
        1: payload = 32'hFFFF_FFFF;
        2: payload = 32'hAAAA_AAAA;
        3: payload = 32'h5555_5555;
        default: payload = $urandom();
      endcase
      send_request(fomf_pkg::CMD_ENQ, ids[i % ID_REGS], payload);
      if (i == SLOTS / 2) send_request(fomf_pkg::CMD_ENQ, 8'h01, $urandom());
    end
    send_request(fomf_pkg::CMD_ENQ, 8'hA5, $urandom());
  endtask

  task automatic test_overwrite_and_drain();
    wait_idle();
    write_reg(fomf_pkg::REG_OVERWRITE, 32'd1);
    send_request(fomf_pkg::CMD_ENQ, 8'h5A, 32'hDEAD_BEEF);
    send_request(fomf_pkg::CMD_CHK, slot_id[head_ptr], $urandom());
    send_request(fomf_pkg::CMD_CHK, slot_id[head_ptr] ^ 8'h01, $urandom());
    send_request(fomf_pkg::CMD_DEQ, ID_W'($urandom_range(0, 255)), $urandom());
  endtask

  task automatic test_backpressure();
    request_t req;
    wait_idle();
    in_gap_on = 1'b0;
    hold_off_cycles = 300;
    repeat (40) begin
      req = random_request(50, 30);
      send_request(req.command, req.id, req.payload);
    end
    in_gap_on = 1'b1;
  endtask

  task automatic test_random_phases();
    request_t req;
    int       mix;
    int       enq_pct;
    int       deq_pct;
    while (requests_sent < ITEM_TARGET) begin
      wait_idle();
      random_config();
      phase_count++;
      in_gap_on = $urandom_range(0, 3) != 0;
      out_stall_on = $urandom_range(0, 3) != 0;
      mix = $urandom_range(0, 2);
      enq_pct = (mix == 0) ? 65 : (mix == 1) ? 25 : 45;
      deq_pct = (mix == 0) ? 20 : (mix == 1) ? 55 : 30;
      repeat ($urandom_range(20, 80)) begin
        req = random_request(enq_pct, deq_pct);
        send_request(req.command, req.id, req.payload);
      end
    end
  endtask

  initial begin
    int      stall_left;
    result_t exp;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with no request pending");
          mismatches++;
        end else begin
          exp = pending_results.pop_front();
          results_checked++;
          if (out_ch.done_res !== exp.done) begin
            $error("done_res: expected %0d, actual %0d", exp.done, out_ch.done_res);
            mismatches++;
          end
          if (out_ch.out_id !== exp.id) begin
            $error("out_id: expected %0h, actual %0h", exp.id, out_ch.out_id);
            mismatches++;
          end
          if (out_ch.out_payload !== exp.payload) begin
            $error("out_payload: expected %0h, actual %0h", exp.payload, out_ch.out_payload);
            mismatches++;
          end
          if (out_ch.fill_count !== exp.fill) begin
            $error("fill_count: expected %0d, actual %0d", exp.fill, out_ch.fill_count);
            mismatches++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_stall_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    cap_reg = fomf_pkg::CAP_RESET;
    overwrite_reg = 1'b0;
    id_count_reg = '0;
    accept_id = '{default: '0};
    head_ptr = '0;
    tail_ptr = '0;
    fill_level = '0;
    in_gap_on = 1'b1;
    out_stall_on = 1'b1;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= fomf_pkg::CMD_NONE;
    in_ch.message_id <= '0;
    in_ch.message_payload <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= fomf_pkg::REG_CAPACITY;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_fill_to_full();
    test_overwrite_and_drain();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Ran %0d requests over %0d random configurations; %0d results compared.",
             requests_sent, phase_count, results_checked);
    $display("Stored %0d, overwrote %0d, rejected %0d, delivered %0d, head matches %0d.",
             stored_count, overwrite_count, reject_count, delivered_count, match_count);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("filtered_overwrite_message_fifo test passed");
    end else begin
      $display("filtered_overwrite_message_fifo test failed");
    end
    $finish;
  end

endmodule
